@@ design/hos_pkg.sv @@
// ----------------------------------------------------------------------------
// hos_pkg: shared types and constants of the hall odometry speed filter
// Widths, command and register codes, reset values and the fixed scale
// factors used by the serial arithmetic units.
// ----------------------------------------------------------------------------
package hos_pkg;

  localparam int POSITION_WIDTH = 32;
  localparam int SPEED_WIDTH    = 24;

  localparam int CMD_W      = 3;
  localparam int ELAPSED_W  = 24;
  localparam int CPR_W      = 12;
  localparam int COEF_W     = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam int OUT_POS_W   = 32;
  localparam int OUT_SPEED_W = 24;

  // rpm in Q4: 60 s * 1e6 us * 16
  localparam int                  SCALE_W   = 30;
  localparam logic [SCALE_W-1:0]  RPM_SCALE = SCALE_W'(960000000);

  localparam int NUM_W = POSITION_WIDTH + SCALE_W;
  localparam int DEN_W = ELAPSED_W + CPR_W;
  localparam int QUO_W = SPEED_WIDTH + 1;
  localparam int SUM_W = SPEED_WIDTH + 1;
  localparam int ACC_W = SPEED_WIDTH + 3;

  localparam int MUL_CNT_W  = $clog2(SCALE_W);
  localparam int DIV_CNT_W  = $clog2(NUM_W);
  localparam int FILT_CNT_W = $clog2(COEF_W);

  localparam logic [QUO_W-1:0] QUO_CAP = QUO_W'(1) << (SPEED_WIDTH - 1);

  localparam logic signed [SPEED_WIDTH-1:0] SPEED_MAX =
    SPEED_WIDTH'((64'd1 << (SPEED_WIDTH - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] ACC_SPEED_MAX =
    ACC_W'((64'd1 << (SPEED_WIDTH - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] ACC_SPEED_MIN = -ACC_SPEED_MAX - ACC_W'(1);

  localparam logic [CPR_W-1:0]  CPR_RESET      = CPR_W'(600);
  localparam logic [COEF_W-1:0] FB_COEF_RESET  = COEF_W'(27984);
  localparam logic [COEF_W-1:0] IN_COEF_RESET  = COEF_W'(2386);

  typedef enum logic [CMD_W-1:0] {
    CMD_HALL_A = 3'd0,
    CMD_HALL_B = 3'd1,
    CMD_HALL_C = 3'd2,
    CMD_PULSE  = 3'd3,
    CMD_SAMPLE = 3'd4
  } hos_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNTS_PER_REV = 2'd0,
    CFG_FEEDBACK_COEF  = 2'd1,
    CFG_INPUT_COEF     = 2'd2
  } hos_cfg_idx_e;

  typedef struct packed {
    logic [CPR_W-1:0]  counts_per_rev;
    logic [COEF_W-1:0] feedback_coef;
    logic [COEF_W-1:0] input_coef;
  } hos_cfg_t;

endpackage

@@ design/hos_if.sv @@
// ----------------------------------------------------------------------------
// hos_in_if / hos_out_if: valid-ready channels of the odometry block
// Event transactions in, odometry and speed transactions out.
// ----------------------------------------------------------------------------
interface hos_in_if;
  import hos_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [ELAPSED_W-1:0] elapsed_us;

  modport source (output valid, command, elapsed_us, input ready);
  modport sink   (input valid, command, elapsed_us, output ready);
endinterface

interface hos_out_if;
  import hos_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [OUT_POS_W-1:0]   position;
  logic                          direction;
  logic signed [OUT_SPEED_W-1:0] raw_speed;
  logic signed [OUT_SPEED_W-1:0] filtered_speed;

  modport source (output valid, position, direction, raw_speed, filtered_speed,
                  input ready);
  modport sink   (input valid, position, direction, raw_speed, filtered_speed,
                  output ready);
endinterface

@@ design/hall_odometry_speed_filter_core.sv @@
// ----------------------------------------------------------------------------
// hall_odometry_speed_filter_core: hall odometry with low-pass speed filter
// Tracks hall levels, direction and pulse position; on a sample tick turns
// the position change into signed Q4 rpm and filters it.
// ----------------------------------------------------------------------------
// Every transaction returns one result carrying position, direction and the
// raw and filtered speeds after the update. Hall, pulse and unused commands
// load the result register as they are accepted and may follow each other
// every cycle while the result register drains. A speed sample runs through
// a shift-add multiplier, a restoring divider producing one quotient bit per
// cycle and a serial filter, then hands its result to the result register;
// the divider dominates. No new transaction is taken during a sample.
// Configuration writes are expected only while the block is idle.
module hall_odometry_speed_filter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  hos_in_if.sink                            in_i,
  hos_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [hos_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [hos_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import hos_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_FILT = 5'b01000,
    ST_DONE = 5'b10000
  } hos_state_e;

  hos_state_e                    state_q;
  hos_cfg_t                      cfg_q;

  logic                          hall_a_q, hall_b_q, hall_c_q, dir_q;
  logic                          hall_a_d, hall_b_d, hall_c_d, dir_d;
  logic [POSITION_WIDTH-1:0]     pulse_q, pulse_d, last_q;
  logic signed [SPEED_WIDTH-1:0] filt_q, prev_q, raw_q, raw_d;
  logic                          neg_q, zero_q;

  logic [POSITION_WIDTH-1:0]     diff, mag_d;
  logic signed [SUM_W-1:0]       sum_d;

  logic                          in_fire, out_free, is_sample;
  logic                          mul_start, mul_done, div_done, filt_done;
  logic [NUM_W-1:0]              num;
  logic [DEN_W-1:0]              den;
  logic [SPEED_WIDTH-1:0]        quo;
  logic signed [SPEED_WIDTH-1:0] filt_res;

  logic                          out_valid_q, out_valid_d, out_load;
  logic signed [OUT_POS_W-1:0]   out_pos_q;
  logic                          out_dir_q;
  logic signed [OUT_SPEED_W-1:0] out_raw_q, out_filt_q;

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_sample  = hos_cmd_e'(in_i.command) == CMD_SAMPLE;
  assign mul_start  = in_fire && is_sample;

  // load a new result, else drop the held one once it is taken
  assign out_load    = (in_fire && !is_sample) || ((state_q == ST_DONE) && out_free);
  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  assign diff  = pulse_q - last_q;
  assign mag_d = diff[POSITION_WIDTH-1] ? (~diff + POSITION_WIDTH'(1)) : diff;

  // event decode
  always_comb begin
    hall_a_d = hall_a_q;
    hall_b_d = hall_b_q;
    hall_c_d = hall_c_q;
    dir_d    = dir_q;
    pulse_d  = pulse_q;
    case (hos_cmd_e'(in_i.command))
      CMD_HALL_A: begin
        hall_a_d = ~hall_a_q;
        if (!hall_a_q && hall_c_q) dir_d = 1'b1;
      end
      CMD_HALL_B: hall_b_d = ~hall_b_q;
      CMD_HALL_C: begin
        hall_c_d = ~hall_c_q;
        if (!hall_c_q && hall_a_q) dir_d = 1'b0;
      end
      CMD_PULSE: pulse_d = dir_q ? pulse_q + POSITION_WIDTH'(1)
                                 : pulse_q - POSITION_WIDTH'(1);
      default: ;
    endcase
  end

  // signed raw speed from the capped quotient
  always_comb begin
    if (zero_q) begin
      raw_d = '0;
    end else if (neg_q) begin
      raw_d = $signed(-quo);
    end else if (quo[SPEED_WIDTH-1]) begin
      raw_d = SPEED_MAX;
    end else begin
      raw_d = $signed(quo);
    end
  end

  assign sum_d = SUM_W'(raw_d) + SUM_W'(prev_q);

  hos_scale_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mag_i     (mag_d),
    .elapsed_i (in_i.elapsed_us),
    .cfg_i     (cfg_q),
    .done_o    (mul_done),
    .num_o     (num),
    .den_o     (den)
  );

  hos_rate_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_done && (state_q == ST_MUL)),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  hos_iir_filter u_filt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_done && (state_q == ST_DIV)),
    .cfg_i    (cfg_q),
    .filt_i   (filt_q),
    .sum_i    (sum_d),
    .done_o   (filt_done),
    .result_o (filt_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.counts_per_rev <= CPR_RESET;
      cfg_q.feedback_coef  <= FB_COEF_RESET;
      cfg_q.input_coef     <= IN_COEF_RESET;
    end else if (cfg_we_i) begin
      case (hos_cfg_idx_e'(cfg_idx_i))
        CFG_COUNTS_PER_REV: cfg_q.counts_per_rev <= cfg_data_i[CPR_W-1:0];
        CFG_FEEDBACK_COEF:  cfg_q.feedback_coef  <= cfg_data_i[COEF_W-1:0];
        CFG_INPUT_COEF:     cfg_q.input_coef     <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hall_a_q    <= 1'b0;
      hall_b_q    <= 1'b0;
      hall_c_q    <= 1'b0;
      dir_q       <= 1'b0;
      pulse_q     <= '0;
      last_q      <= '0;
      filt_q      <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            hall_a_q <= hall_a_d;
            hall_b_q <= hall_b_d;
            hall_c_q <= hall_c_d;
            dir_q    <= dir_d;
            pulse_q  <= pulse_d;
            if (is_sample) begin
              last_q  <= pulse_q;
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL:  if (mul_done)  state_q <= ST_DIV;
        ST_DIV:  if (div_done)  state_q <= ST_FILT;
        ST_FILT: if (filt_done) state_q <= ST_DONE;
        ST_DONE: begin
          // hold the sample result until the output register is free
          if (out_free) begin
            filt_q  <= filt_res;
            prev_q  <= raw_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      neg_q  <= diff[POSITION_WIDTH-1];
      zero_q <= diff == '0;
    end
    if (div_done && (state_q == ST_DIV)) begin
      raw_q <= raw_d;
    end
    if (in_fire && !is_sample) begin
      out_pos_q  <= OUT_POS_W'($signed(pulse_d));
      out_dir_q  <= dir_d;
      out_raw_q  <= OUT_SPEED_W'(prev_q);
      out_filt_q <= OUT_SPEED_W'(filt_q);
    end else if ((state_q == ST_DONE) && out_free) begin
      out_pos_q  <= OUT_POS_W'($signed(pulse_q));
      out_dir_q  <= dir_q;
      out_raw_q  <= OUT_SPEED_W'(raw_q);
      out_filt_q <= OUT_SPEED_W'(filt_res);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.position       = out_pos_q;
  assign out_o.direction      = out_dir_q;
  assign out_o.raw_speed      = out_raw_q;
  assign out_o.filtered_speed = out_filt_q;

endmodule

@@ design/hos_scale_mul.sv @@
// ----------------------------------------------------------------------------
// hos_scale_mul: serial shift-add multiplier pair
// Forms |dpos| * rpm scale and elapsed_us * counts_per_rev, one multiplier
// bit per cycle, for the speed division.
// ----------------------------------------------------------------------------
module hos_scale_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [hos_pkg::POSITION_WIDTH-1:0]  mag_i,
  input  logic [hos_pkg::ELAPSED_W-1:0]       elapsed_i,
  input  hos_pkg::hos_cfg_t                   cfg_i,
  output logic                                done_o,
  output logic [hos_pkg::NUM_W-1:0]           num_o,
  output logic [hos_pkg::DEN_W-1:0]           den_o
);
  import hos_pkg::*;

  logic                      busy_q;
  logic                      done_q;
  logic [MUL_CNT_W-1:0]      cnt_q;
  logic [NUM_W-1:0]          num_q;
  logic [DEN_W-1:0]          den_q;
  logic [POSITION_WIDTH-1:0] mag_q;
  logic [ELAPSED_W-1:0]      el_q;
  logic [POSITION_WIDTH:0]   num_sum;
  logic [ELAPSED_W:0]        den_sum;

  // add the multiplicand into the high half when the low bit is set, then shift
  assign num_sum = {1'b0, num_q[NUM_W-1:SCALE_W]} + (num_q[0] ? {1'b0, mag_q} : '0);
  assign den_sum = {1'b0, den_q[DEN_W-1:CPR_W]} + (den_q[0] ? {1'b0, el_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + MUL_CNT_W'(1);
        if (cnt_q == MUL_CNT_W'(SCALE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {POSITION_WIDTH'(0), RPM_SCALE};
      den_q <= {ELAPSED_W'(0), cfg_i.counts_per_rev};
      mag_q <= mag_i;
      el_q  <= elapsed_i;
    end else if (busy_q) begin
      num_q <= {num_sum, num_q[SCALE_W-1:1]};
      // the shorter product finishes early: hold it
      if (cnt_q < MUL_CNT_W'(CPR_W)) begin
        den_q <= {den_sum, den_q[CPR_W-1:1]};
      end
    end
  end

  assign done_o = done_q;
  assign num_o  = num_q;
  assign den_o  = den_q;

endmodule

@@ design/hos_rate_div.sv @@
// ----------------------------------------------------------------------------
// hos_rate_div: restoring divider for the rpm quotient
// One quotient bit per cycle; the quotient is capped one above the largest
// positive speed.
// ----------------------------------------------------------------------------
module hos_rate_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [hos_pkg::NUM_W-1:0]        num_i,
  input  logic [hos_pkg::DEN_W-1:0]        den_i,
  output logic                             done_o,
  output logic [hos_pkg::SPEED_WIDTH-1:0]  quo_o
);
  import hos_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]     num_q;
  logic [DEN_W-1:0]     den_q;
  logic [DEN_W-1:0]     rem_q;
  logic [QUO_W-1:0]     quo_q;
  logic                 ovf_q;
  logic [DEN_W:0]       rem_sh;
  logic [DEN_W:0]       rem_diff;
  logic                 ge;

  assign rem_sh   = {rem_q, num_q[NUM_W-1]};
  assign ge       = rem_sh >= {1'b0, den_q};
  assign rem_diff = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], ge};
      // a bit shifted out of the top means the quotient is far beyond the cap
      ovf_q <= ovf_q | quo_q[QUO_W-1];
    end
  end

  assign done_o = done_q;
  assign quo_o  = (ovf_q || (quo_q > QUO_CAP)) ? QUO_CAP[SPEED_WIDTH-1:0]
                                               : quo_q[SPEED_WIDTH-1:0];

endmodule

@@ design/hos_iir_filter.sv @@
// ----------------------------------------------------------------------------
// hos_iir_filter: serial first-order low-pass on the speed
// Scans both Q0.15 coefficients one bit per cycle, then rounds half up and
// saturates to the speed width.
// ----------------------------------------------------------------------------
module hos_iir_filter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  hos_pkg::hos_cfg_t                      cfg_i,
  input  logic signed [hos_pkg::SPEED_WIDTH-1:0] filt_i,
  input  logic signed [hos_pkg::SUM_W-1:0]       sum_i,
  output logic                                   done_o,
  output logic signed [hos_pkg::SPEED_WIDTH-1:0] result_o
);
  import hos_pkg::*;

  logic                          busy_q;
  logic                          done_q;
  logic [FILT_CNT_W-1:0]         cnt_q;
  logic [COEF_W-1:0]             fb_q;
  logic [COEF_W-1:0]             ic_q;
  logic signed [SPEED_WIDTH-1:0] filt_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic signed [ACC_W-1:0]       hi_q;
  logic                          round_q;
  logic signed [ACC_W:0]         step_sum;
  logic signed [ACC_W-1:0]       rounded;

  // partial products enter at the top; the low bits drop off, only the last
  // one decides rounding
  assign step_sum = (ACC_W+1)'(hi_q)
                  + (fb_q[0] ? (ACC_W+1)'(filt_q) : '0)
                  + (ic_q[0] ? (ACC_W+1)'(sum_q)  : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + FILT_CNT_W'(1);
        if (cnt_q == FILT_CNT_W'(COEF_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      fb_q    <= cfg_i.feedback_coef;
      ic_q    <= cfg_i.input_coef;
      filt_q  <= filt_i;
      sum_q   <= sum_i;
      hi_q    <= '0;
      round_q <= 1'b0;
    end else if (busy_q) begin
      fb_q    <= {1'b0, fb_q[COEF_W-1:1]};
      ic_q    <= {1'b0, ic_q[COEF_W-1:1]};
      hi_q    <= step_sum[ACC_W:1];
      round_q <= step_sum[0];
    end
  end

  assign rounded = hi_q + ACC_W'(round_q);

  always_comb begin
    if (rounded > ACC_SPEED_MAX) begin
      result_o = ACC_SPEED_MAX[SPEED_WIDTH-1:0];
    end else if (rounded < ACC_SPEED_MIN) begin
      result_o = ACC_SPEED_MIN[SPEED_WIDTH-1:0];
    end else begin
      result_o = rounded[SPEED_WIDTH-1:0];
    end
  end

  assign done_o = done_q;

endmodule
